/* sv/mtf_pkg.sv */
package mtf_pkg;

    localparam int ID_W = 6;

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    // Request from the sequencer to the entry store.
    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [ID_W-1:0] wdata;
        logic [ID_W-1:0] raddr;
        logic            clr;
        logic [ID_W-1:0] clr_lo;
        logic [ID_W-1:0] clr_hi;
    } store_req_t;

endpackage

/* sv/mru_move_to_front_list_core.sv */
// Query: scans entries up to the match (or the whole live list), then reads one more entry.
// Add: scans to the match or list end, shifts earlier entries back, then writes the front.
// Shrinking resize: scans each remaining live entry; any other item is handled from idle.
// One item at a time; each step uses the entry store's read and write ports and the compare.
// A query also holds before its result while the previous result beat is still waiting.
// Reset clears the live size to zero and marks every entry as holding its index plus one.
module mru_move_to_front_list_core
    import mtf_pkg::*;
#(
    parameter int MAX_IDS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      kind,
    input  logic [ID_W-1:0] desktop,
    input  logic [ID_W-1:0] target_size,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [ID_W-1:0] next_desktop
);

    localparam int IDX_W = $clog2(MAX_IDS);
    localparam logic [ID_W-1:0] MAX_SZ = ID_W'(MAX_IDS);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN_RD   = 3'd1;
    localparam logic [2:0] S_SCAN_CHK  = 3'd2;
    localparam logic [2:0] S_FINAL_RD  = 3'd3;
    localparam logic [2:0] S_FINAL_CHK = 3'd4;
    localparam logic [2:0] S_SHIFT_RD  = 3'd5;
    localparam logic [2:0] S_SHIFT_WR  = 3'd6;
    localparam logic [2:0] S_FRONT     = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       kind_reg, kind_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [ID_W-1:0]  ns_reg, ns_next;
    logic [ID_W-1:0]  size_reg, size_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [ID_W-1:0]  result_reg, result_next;

    store_req_t       req;
    logic [ID_W-1:0]  rd_val;
    logic [ID_W-1:0]  limit;
    logic [ID_W-1:0]  idx_p1;
    logic             is_last;
    logic             match;
    logic [ID_W-1:0]  ns_sat;

    mtf_store #(
        .MAX_IDS (MAX_IDS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rd_val (rd_val)
    );

    assign ns_sat  = (target_size > MAX_SZ) ? MAX_SZ : target_size;
    assign limit   = (kind_reg == KIND_RESIZE) ? ns_reg : size_reg;
    assign idx_p1  = ID_W'(idx_reg) + ID_W'(1);
    assign is_last = (idx_p1 >= limit);
    assign match   = (rd_val == id_reg);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        ns_next        = ns_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        req            = '0;
        req.raddr      = ID_W'(idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    id_next   = desktop;
                    ns_next   = ns_sat;
                    idx_next  = '0;
                    unique case (kind)
                        KIND_QUERY:
                        begin
                            state_next = (size_reg == '0) ? S_FINAL_RD : S_SCAN_RD;
                        end
                        KIND_ADD:
                        begin
                            if ((size_reg != '0) && (desktop <= size_reg))
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        KIND_RESIZE:
                        begin
                            if (ns_sat >= size_reg)
                            begin
                                req.clr    = 1'b1;
                                req.clr_lo = size_reg;
                                req.clr_hi = ns_sat;
                                size_next  = ns_sat;
                            end
                            else if (ns_sat == '0)
                            begin
                                size_next = '0;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                unique case (kind_reg)
                    KIND_QUERY:
                    begin
                        if (match || is_last)
                        begin
                            idx_next   = (match && !is_last) ? (idx_reg + IDX_W'(1)) : '0;
                            state_next = S_FINAL_RD;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_SCAN_RD;
                        end
                    end
                    KIND_ADD:
                    begin
                        if (match || is_last)
                        begin
                            state_next = (idx_reg == '0) ? S_FRONT : S_SHIFT_RD;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        if (rd_val > ns_reg)
                        begin
                            req.we    = 1'b1;
                            req.waddr = ID_W'(idx_reg);
                            req.wdata = ns_reg;
                        end
                        if (is_last)
                        begin
                            size_next  = ns_reg;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_FINAL_RD:
            begin
                state_next = S_FINAL_CHK;
            end
            S_FINAL_CHK:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = (size_reg == '0) ? ID_W'(1) : rd_val;
                    state_next     = S_IDLE;
                end
            end
            S_SHIFT_RD:
            begin
                req.raddr  = ID_W'(idx_reg - IDX_W'(1));
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                req.we     = 1'b1;
                req.waddr  = ID_W'(idx_reg);
                req.wdata  = rd_val;
                idx_next   = idx_reg - IDX_W'(1);
                state_next = (idx_reg == IDX_W'(1)) ? S_FRONT : S_SHIFT_RD;
            end
            S_FRONT:
            begin
                req.we     = 1'b1;
                req.waddr  = '0;
                req.wdata  = id_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        ns_reg     <= ns_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign next_desktop = result_reg;

endmodule

/* sv/mtf_store.sv */
module mtf_store
    import mtf_pkg::*;
#(
    parameter int MAX_IDS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  store_req_t      req,
    output logic [ID_W-1:0] rd_val
);

    localparam int IDX_W = $clog2(MAX_IDS);

    logic [ID_W-1:0]    mem [MAX_IDS];
    logic [ID_W-1:0]    mem_q;
    logic [IDX_W-1:0]   ridx_reg;
    logic [MAX_IDS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[IDX_W-1:0]] <= req.wdata;
        end
        mem_q    <= mem[req.raddr[IDX_W-1:0]];
        ridx_reg <= req.raddr[IDX_W-1:0];
    end

    // A slot that was never written, or was refilled by a grow, reads as its index plus one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_IDS; i++)
            begin
                if (req.clr && (ID_W'(i) >= req.clr_lo) && (ID_W'(i) < req.clr_hi))
                begin
                    valid_reg[i] <= 1'b0;
                end
                if (req.we && (req.waddr[IDX_W-1:0] == IDX_W'(i)))
                begin
                    valid_reg[i] <= 1'b1;
                end
            end
        end
    end

    assign rd_val = valid_reg[ridx_reg] ? mem_q : (ID_W'(ridx_reg) + ID_W'(1));

endmodule
